/* src/adsr_pkg.sv */
// Shared types, constants and the step-scaling function of the ADSR envelope generator.
package adsr_pkg;

    localparam int LEVEL_W   = 32;
    localparam int PHASE_W   = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int FRAC_W    = 24;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [PHASE_W-1:0] phase_t;

    // Phase codes.
    localparam phase_t PH_LOW     = 3'd0;
    localparam phase_t PH_ATTACK  = 3'd1;
    localparam phase_t PH_DECAY   = 3'd2;
    localparam phase_t PH_SUSTAIN = 3'd3;
    localparam phase_t PH_RELEASE = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PEAK    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DECAY   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SUSTAIN = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RELEASE = 3'd4;

    // Reset values, Q8.24.
    localparam level_t ATTACK_RST  = 32'd16777;
    localparam level_t PEAK_RST    = 32'd16777216;
    localparam level_t DECAY_RST   = 32'd8389;
    localparam level_t SUSTAIN_RST = 32'd8388608;
    localparam level_t RELEASE_RST = 32'd3355;

    // With the peak at 1.0 the reset steps equal the reset rates.
    localparam level_t ATTACK_STEP_RST  = ATTACK_RST;
    localparam level_t DECAY_STEP_RST   = DECAY_RST;
    localparam level_t RELEASE_STEP_RST = RELEASE_RST;

    typedef struct packed {
        phase_t phase;
        level_t level;
    } env_state_t;

    typedef struct packed {
        level_t attack_step;
        level_t decay_step;
        level_t release_step;
        level_t peak;
        level_t sustain;
    } env_cfg_t;

    // Per-tick step: rate times peak, shifted down to Q8.24, saturated to 32 bits.
    function automatic level_t scaled_step(input level_t rate, input level_t peak);
        logic [2*LEVEL_W-1:0] prod;
        prod = {{LEVEL_W{1'b0}}, rate} * {{LEVEL_W{1'b0}}, peak};
        if (|prod[2*LEVEL_W-1:LEVEL_W+FRAC_W]) begin
            scaled_step = {LEVEL_W{1'b1}};
        end else begin
            scaled_step = prod[LEVEL_W+FRAC_W-1:FRAC_W];
        end
    endfunction

endpackage

/* src/adsr_next.sv */
// Next-state logic of the envelope for one update tick.
module adsr_next (
    input  adsr_pkg::env_state_t cur,
    input  adsr_pkg::env_cfg_t   cfg,
    input  logic                 gate,
    output adsr_pkg::env_state_t nxt
);
    import adsr_pkg::*;

    logic [LEVEL_W:0] rise_sum;
    logic             dec_under;
    level_t           dec_diff;
    logic             rel_under;
    level_t           rel_diff;

    always_comb begin
        rise_sum  = {1'b0, cur.level} + {1'b0, cfg.attack_step};
        dec_under = cfg.decay_step > cur.level;
        dec_diff  = cur.level - cfg.decay_step;
        rel_under = cfg.release_step > cur.level;
        rel_diff  = cur.level - cfg.release_step;
    end

    always_comb begin
        nxt = cur;
        case (cur.phase)
            PH_ATTACK: begin
                nxt.level = rise_sum[LEVEL_W] ? {LEVEL_W{1'b1}} : rise_sum[LEVEL_W-1:0];
                if (!gate) begin
                    nxt.phase = PH_RELEASE;
                end else if (nxt.level > cfg.peak) begin
                    nxt.level = cfg.peak;
                    nxt.phase = PH_DECAY;
                end
            end
            PH_DECAY: begin
                nxt.level = dec_under ? '0 : dec_diff;
                if (!gate) begin
                    nxt.phase = PH_RELEASE;
                end else if (dec_under || (dec_diff < cfg.sustain)) begin
                    nxt.level = cfg.sustain;
                    nxt.phase = PH_SUSTAIN;
                end
            end
            PH_SUSTAIN: begin
                nxt.level = cfg.sustain;
                nxt.phase = gate ? PH_SUSTAIN : PH_RELEASE;
            end
            PH_RELEASE: begin
                if (rel_under) begin
                    nxt.level = '0;
                    nxt.phase = PH_LOW;
                end else begin
                    nxt.level = rel_diff;
                end
            end
            default: begin
                nxt.level = '0;
                nxt.phase = gate ? PH_ATTACK : PH_LOW;
            end
        endcase
    end

endmodule

/* src/adsr_envelope_generator.sv */
// Top level of the linear ADSR envelope generator.
//
// Each transaction on the s_ channel is one update tick carrying the gate bit.
// For every tick the m_ channel delivers one transaction with the envelope level
// (unsigned Q8.24) and the phase after that tick (0 low, 1 attack, 2 decay,
// 3 sustain, 4 release).
// A tick accepted on s_ is registered in the input stage, run through the next-state
// logic into the envelope state registers and appears on m_ from there.
// One tick per cycle is sustained while m_tready stays high; the envelope state
// registers double as the result register, and one input stage lets a tick wait while
// a result stalls. When m_tready is low, the pending result holds and the input stage
// takes one more tick; after that s_tready drops until the result is taken.
// The per-phase steps (rate times peak) are multiplied when a configuration
// register is written, so configuration takes effect at the write edge.
// Reset (aresetn low, synchronous) restores the default rates and levels,
// empties both stages and sets the phase to low with a level of zero.
module adsr_envelope_generator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [adsr_pkg::S_TDATA_W-1:0]  s_tdata,   // [0] gate, [7:1] zero
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [adsr_pkg::M_TDATA_W-1:0]  m_tdata,   // [31:0] level, [34:32] phase
    input  logic                            cfg_we,
    input  logic [adsr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [adsr_pkg::LEVEL_W-1:0]    cfg_wdata
);
    import adsr_pkg::*;

    level_t     attack_reg, peak_reg, decay_reg, sustain_reg, release_reg;
    level_t     attack_step_reg, decay_step_reg, release_step_reg;
    level_t     attack_src, peak_src, decay_src, release_src;
    logic       in_valid_reg;
    logic       gate_reg;
    logic       out_valid_reg;
    env_state_t env_reg;
    env_state_t env_next;
    env_cfg_t   cfg;
    logic       advance;

    // Operands for the step multipliers include the value being written.
    always_comb begin
        attack_src  = (cfg_we && cfg_addr == REG_ATTACK)  ? cfg_wdata : attack_reg;
        peak_src    = (cfg_we && cfg_addr == REG_PEAK)    ? cfg_wdata : peak_reg;
        decay_src   = (cfg_we && cfg_addr == REG_DECAY)   ? cfg_wdata : decay_reg;
        release_src = (cfg_we && cfg_addr == REG_RELEASE) ? cfg_wdata : release_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_reg       <= ATTACK_RST;
            peak_reg         <= PEAK_RST;
            decay_reg        <= DECAY_RST;
            sustain_reg      <= SUSTAIN_RST;
            release_reg      <= RELEASE_RST;
            attack_step_reg  <= ATTACK_STEP_RST;
            decay_step_reg   <= DECAY_STEP_RST;
            release_step_reg <= RELEASE_STEP_RST;
        end else if (cfg_we) begin
            attack_reg       <= attack_src;
            peak_reg         <= peak_src;
            decay_reg        <= decay_src;
            release_reg      <= release_src;
            if (cfg_addr == REG_SUSTAIN) begin
                sustain_reg <= cfg_wdata;
            end
            attack_step_reg  <= scaled_step(attack_src, peak_src);
            decay_step_reg   <= scaled_step(decay_src, peak_src);
            release_step_reg <= scaled_step(release_src, peak_src);
        end
    end

    always_comb begin
        cfg.attack_step  = attack_step_reg;
        cfg.decay_step   = decay_step_reg;
        cfg.release_step = release_step_reg;
        cfg.peak         = peak_reg;
        cfg.sustain      = sustain_reg;
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    adsr_next u_next (
        .cur  (env_reg),
        .cfg  (cfg),
        .gate (gate_reg),
        .nxt  (env_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            env_reg.phase <= PH_LOW;
            env_reg.level <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                env_reg       <= env_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            gate_reg <= s_tdata[0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - PHASE_W - LEVEL_W){1'b0}}, env_reg.phase, env_reg.level};

    // In the low phase the level is always zero.
    a_low_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (env_reg.phase == PH_LOW) |-> (env_reg.level == '0))
        else $error("level not zero in low phase");

    // A waiting tick is not overwritten while the result stalls.
    a_hold_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input stage accepted while full and stalled");

    // A tick that advances always produces a result in the next cycle.
    a_advance_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("advanced tick produced no result");

    // An accepted tick is held in the input stage.
    a_accept_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted tick lost");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the linear ADSR envelope generator.
`timescale 1ns / 1ps

module tb_top;
    import adsr_pkg::*;

    localparam int CYCLE_LIMIT       = 400000;
    localparam int NUM_SETTINGS      = 12;
    localparam int TICKS_PER_SETTING = 128;

    // Marks a table row that writes no register.
    localparam logic [CFG_ADDR_W-1:0] REG_NONE = 3'd7;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    // A tick row uses value as the expected level when pinned; a register row writes it.
    typedef struct packed {
        row_kind_t             kind;
        logic                  gate;
        logic                  pinned;
        phase_t                exp_phase;
        logic [CFG_ADDR_W-1:0] reg_idx;
        level_t                value;
    } dir_row_t;

    localparam int NUM_ROWS = 31;

    dir_row_t dir_tbl [NUM_ROWS] = '{
        '{ROW_TICK, 1'b0, 1'b1, PH_LOW,     REG_NONE,    32'd0},
        '{ROW_TICK, 1'b1, 1'b1, PH_ATTACK,  REG_NONE,    32'd0},
        '{ROW_TICK, 1'b1, 1'b1, PH_ATTACK,  REG_NONE,    32'd16777},
        '{ROW_TICK, 1'b0, 1'b1, PH_RELEASE, REG_NONE,    32'd33554},
        '{ROW_CFG,  1'b0, 1'b0, PH_LOW,     REG_RELEASE, 32'd0},
        '{ROW_TICK, 1'b1, 1'b1, PH_RELEASE, REG_NONE,    32'd33554},
        '{ROW_CFG,  1'b0, 1'b0, PH_LOW,     REG_RELEASE, 32'hFFFF_FFFF},
        '{ROW_TICK, 1'b0, 1'b1, PH_LOW,     REG_NONE,    32'd0},
        '{ROW_CFG,  1'b0, 1'b0, PH_LOW,     REG_ATTACK,  32'h0080_0000},
        '{ROW_CFG,  1'b0, 1'b0, PH_LOW,     REG_DECAY,   32'h0100_0001},
        '{ROW_TICK, 1'b1, 1'b1, PH_ATTACK,  REG_NONE,    32'd0},
        '{ROW_TICK, 1'b1, 1'b1, PH_ATTACK,  REG_NONE,    32'd8388608},
        '{ROW_TICK, 1'b1, 1'b1, PH_ATTACK,  REG_NONE,    32'd16777216},
        '{ROW_TICK, 1'b1, 1'b1, PH_DECAY,   REG_NONE,    32'd16777216},
        '{ROW_TICK, 1'b0, 1'b1, PH_RELEASE, REG_NONE,    32'd0},
        '{ROW_TICK, 1'b0, 1'b1, PH_LOW,     REG_NONE,    32'd0},
        '{ROW_CFG,  1'b0, 1'b0, PH_LOW,     REG_SUSTAIN, 32'hFFFF_FFFF},
        '{ROW_CFG,  1'b0, 1'b0, PH_LOW,     REG_ATTACK,  32'hFFFF_FFFF},
        '{ROW_TICK, 1'b1, 1'b1, PH_ATTACK,  REG_NONE,    32'd0},
        '{ROW_TICK, 1'b1, 1'b1, PH_DECAY,   REG_NONE,    32'd16777216},
        '{ROW_TICK, 1'b1, 1'b1, PH_SUSTAIN, REG_NONE,    32'hFFFF_FFFF},
        '{ROW_TICK, 1'b1, 1'b1, PH_SUSTAIN, REG_NONE,    32'hFFFF_FFFF},
        '{ROW_TICK, 1'b0, 1'b1, PH_RELEASE, REG_NONE,    32'hFFFF_FFFF},
        '{ROW_TICK, 1'b0, 1'b1, PH_RELEASE, REG_NONE,    32'd0},
        '{ROW_TICK, 1'b0, 1'b1, PH_LOW,     REG_NONE,    32'd0},
        '{ROW_CFG,  1'b0, 1'b0, PH_LOW,     REG_PEAK,    32'hFFFF_FFFF},
        '{ROW_TICK, 1'b1, 1'b1, PH_ATTACK,  REG_NONE,    32'd0},
        '{ROW_TICK, 1'b1, 1'b1, PH_ATTACK,  REG_NONE,    32'hFFFF_FFFF},
        '{ROW_TICK, 1'b1, 1'b1, PH_ATTACK,  REG_NONE,    32'hFFFF_FFFF},
        '{ROW_TICK, 1'b0, 1'b1, PH_RELEASE, REG_NONE,    32'hFFFF_FFFF},
        '{ROW_TICK, 1'b0, 1'b0, PH_RELEASE, REG_NONE,    32'd0}
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = REG_ATTACK;
    logic [LEVEL_W-1:0]     cfg_wdata = '0;

    // Predictor state: register copies and the envelope itself.
    level_t cfg_attack  = ATTACK_RST;
    level_t cfg_peak    = PEAK_RST;
    level_t cfg_decay   = DECAY_RST;
    level_t cfg_sustain = SUSTAIN_RST;
    level_t cfg_release = RELEASE_RST;
    phase_t env_phase   = PH_LOW;
    level_t env_level   = '0;

    env_state_t pending_env [$];

    int cycle_count     = 0;
    int err_count       = 0;
    int tick_count      = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int s_calm_left     = 0;
    int m_calm_left     = 0;
    int phase_hits [8]  = '{default: 0};

    adsr_envelope_generator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still outstanding", $time, pending_env.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // Per-tick level change: rate times peak in Q8.24, clipped to 32 bits.
    function automatic level_t rate_to_step(input level_t rate);
        logic [2*LEVEL_W-1:0] prod;
        prod = {{LEVEL_W{1'b0}}, rate} * {{LEVEL_W{1'b0}}, cfg_peak};
        prod = prod >> FRAC_W;
        return (prod[2*LEVEL_W-1:LEVEL_W] != '0) ? '1 : prod[LEVEL_W-1:0];
    endfunction

    function automatic env_state_t advance_envelope(input logic gate_on);
        level_t         delta;
        logic [LEVEL_W:0] sum;
        logic           undershoot;
        case (env_phase)
            PH_ATTACK: begin
                delta     = rate_to_step(cfg_attack);
                sum       = {1'b0, env_level} + {1'b0, delta};
                env_level = sum[LEVEL_W] ? '1 : sum[LEVEL_W-1:0];
                if (!gate_on) begin
                    env_phase = PH_RELEASE;
                end else if (env_level > cfg_peak) begin
                    env_level = cfg_peak;
                    env_phase = PH_DECAY;
                end
            end
            PH_DECAY: begin
                delta      = rate_to_step(cfg_decay);
                undershoot = delta > env_level;
                env_level  = undershoot ? '0 : env_level - delta;
                if (!gate_on) begin
                    env_phase = PH_RELEASE;
                end else if (undershoot || env_level < cfg_sustain) begin
                    env_level = cfg_sustain;
                    env_phase = PH_SUSTAIN;
                end
            end
            PH_SUSTAIN: begin
                env_level = cfg_sustain;
                if (!gate_on) env_phase = PH_RELEASE;
            end
            PH_RELEASE: begin
                delta = rate_to_step(cfg_release);
                if (delta > env_level) begin
                    env_level = '0;
                    env_phase = PH_LOW;
                end else begin
                    env_level = env_level - delta;
                end
            end
            default: begin
                env_level = '0;
                env_phase = gate_on ? PH_ATTACK : PH_LOW;
            end
        endcase
        return {env_phase, env_level};
    endfunction

    // Idle cycles before the next transaction, with occasional back-to-back stretches.
    function automatic int idle_cycles(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm_left = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic level_t rand_rate();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return $urandom;
            default: return $urandom_range(32'h0100_0000, 32'h0008_0000);
        endcase
    endfunction

    task automatic push_tick(input logic gate_on, input logic pinned = 1'b0,
                             input env_state_t typed = '0);
        int         gap;
        env_state_t predicted;
        gap = idle_cycles(s_calm_left);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(gate_on);
        do @(posedge aclk); while (!s_tready);
        predicted = advance_envelope(gate_on);
        pending_env.insert(pending_env.size(), pinned ? typed : predicted);
        tick_count++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_env.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input level_t val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ATTACK:  cfg_attack  = val;
            REG_PEAK:    cfg_peak    = val;
            REG_DECAY:   cfg_decay   = val;
            REG_SUSTAIN: cfg_sustain = val;
            REG_RELEASE: cfg_release = val;
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
    endtask

    initial begin : result_sink
        int         stall;
        env_state_t got;
        env_state_t want;
        wait (aresetn === 1'b1);
        forever begin
            stall = idle_cycles(m_calm_left);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = m_tdata[PHASE_W+LEVEL_W-1:0];
            if (pending_env.size() == 0) begin
                $display("%0t: result with nothing expected: level %h, phase %0d",
                         $time, got.level, got.phase);
                err_count++;
            end else begin
                want = pending_env[0];
                pending_env.delete(0);
                if (got.level !== want.level) begin
                    $display("%0t: level mismatch: expected %h, actual %h",
                             $time, want.level, got.level);
                    err_count++;
                end
                if (got.phase !== want.phase) begin
                    $display("%0t: phase mismatch: expected %0d, actual %0d",
                             $time, want.phase, got.phase);
                    err_count++;
                end
                results_checked++;
                phase_hits[got.phase]++;
            end
        end
    end

    initial begin : stimulus
        level_t atk_v, pk_v, dec_v, sus_v, rls_v;
        int     hold_len, off_len, sent_here;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].kind == ROW_CFG) begin
                drain_results();
                write_reg(dir_tbl[i].reg_idx, dir_tbl[i].value);
            end else begin
                push_tick(dir_tbl[i].gate, dir_tbl[i].pinned,
                          {dir_tbl[i].exp_phase, dir_tbl[i].value});
            end
        end

        for (int set_i = 0; set_i < NUM_SETTINGS; set_i++) begin
            // The sender holds off here until every outstanding result is back.
            drain_results();
            if (set_i == 0) begin
                {atk_v, pk_v, dec_v, sus_v, rls_v} = '1;
            end else if (set_i == 1) begin
                {atk_v, pk_v, dec_v, sus_v, rls_v} = '0;
            end else begin
                case ($urandom_range(0, 7))
                    0: pk_v = '1;
                    1: pk_v = $urandom;
                    default: pk_v = $urandom_range(32'h0200_0000, 32'h0040_0000);
                endcase
                case ($urandom_range(0, 7))
                    0: sus_v = '0;
                    1: sus_v = '1;
                    2: sus_v = $urandom;
                    default: sus_v = $urandom_range(pk_v, 0);
                endcase
                atk_v = rand_rate();
                dec_v = rand_rate();
                rls_v = rand_rate();
            end
            write_reg(REG_ATTACK, atk_v);
            write_reg(REG_PEAK, pk_v);
            write_reg(REG_DECAY, dec_v);
            write_reg(REG_SUSTAIN, sus_v);
            write_reg(REG_RELEASE, rls_v);

            // Mostly note-on / note-off pairs of random length.
            sent_here = 0;
            while (sent_here < TICKS_PER_SETTING) begin
                if ($urandom_range(0, 9) < 8) begin
                    hold_len = $urandom_range(1, 64);
                    off_len  = $urandom_range(1, 48);
                    repeat (hold_len) push_tick(1'b1);
                    repeat (off_len) push_tick(1'b0);
                    sent_here += hold_len + off_len;
                end else begin
                    repeat (16) push_tick(1'($urandom_range(0, 1)));
                    sent_here += 16;
                end
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        $display("Sent %0d ticks with %0d register writes; %0d results checked, %0d errors.",
                 tick_count, reg_writes, results_checked, err_count);
        $display("Results by phase: low %0d, attack %0d, decay %0d, sustain %0d, release %0d.",
                 phase_hits[PH_LOW], phase_hits[PH_ATTACK], phase_hits[PH_DECAY],
                 phase_hits[PH_SUSTAIN], phase_hits[PH_RELEASE]);
        if (err_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

/* sim.f */
src/adsr_pkg.sv
src/adsr_next.sv
src/adsr_envelope_generator.sv
dv/tb_top.sv
